### rtl/core/lgrs_pkg.sv
// Shared types, constants and the Life stencil for the row stepper.
`default_nettype none
package lgrs_pkg;

  localparam int RowBits      = 64;
  localparam int WidthBits    = 7;
  localparam int RowCellsDflt = 64;
  localparam logic [WidthBits-1:0] RowWidthReset = WidthBits'(64);

  // queue between front and back
  localparam int QDepth    = 2;
  localparam int QPtrBits  = $clog2(QDepth);
  localparam int QCntBits  = $clog2(QDepth + 1);

  typedef logic [RowBits-1:0] row_t;

  // one accepted row as the back end needs it
  typedef struct packed {
    row_t above;   // row above the held middle row
    row_t middle;  // held middle row
    row_t cur;     // incoming row, already masked
    logic has_mid; // a successor of the middle row is due
    logic last;    // successor of cur is due as well
  } lgrs_entry_t;

  // B3/S23 successor of mid, neighbours up and down; all three rows are cut to
  // the current mask first, so rows held across a width change lose their
  // out-of-range cells
  function automatic row_t life_row(input row_t up, input row_t mid,
                                    input row_t down, input row_t mask);
    row_t   um, mm, dm;
    row_t   upl, upr, midl, midr, dnl, dnr, res;
    logic [3:0] n;
    um   = up & mask;
    mm   = mid & mask;
    dm   = down & mask;
    upl  = um << 1;    upr  = um >> 1;
    midl = mm << 1;    midr = mm >> 1;
    dnl  = dm << 1;    dnr  = dm >> 1;
    res  = '0;
    for (int i = 0; i < RowBits; i++) begin
      n = 4'(upl[i]) + 4'(um[i]) + 4'(upr[i]) + 4'(midl[i]) + 4'(midr[i])
        + 4'(dnl[i]) + 4'(dm[i]) + 4'(dnr[i]);
      res[i] = (n == 4'd3) || (mm[i] && (n == 4'd2));
    end
    return res & mask;
  endfunction

endpackage
`default_nettype wire

### rtl/core/lgrs_row_in_if.sv
// Input channel: one grid row per transaction.
`default_nettype none
interface lgrs_row_in_if;
  logic          valid;
  logic          ready;
  lgrs_pkg::row_t row_cells;
  logic          last_row;

  modport source (output valid, output row_cells, output last_row, input ready);
  modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface
`default_nettype wire

### rtl/core/lgrs_row_out_if.sv
// Output channel: one next-generation row per transaction.
`default_nettype none
interface lgrs_row_out_if;
  logic          valid;
  logic          ready;
  lgrs_pkg::row_t next_row;
  logic          last_out;

  modport source (output valid, output next_row, output last_out, input ready);
  modport sink   (input valid, input next_row, input last_out, output ready);
endinterface
`default_nettype wire

### rtl/core/lgrs_queue.sv
// Short FIFO of row entries between the front and back ends.
`default_nettype none
module lgrs_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire lgrs_pkg::lgrs_entry_t push_data,
  output logic                       full,
  output logic                       head_valid,
  output lgrs_pkg::lgrs_entry_t      head,
  input  wire logic                  pop
);

  lgrs_pkg::lgrs_entry_t              mem [lgrs_pkg::QDepth];
  logic [lgrs_pkg::QPtrBits-1:0]      wr_ptr;
  logic [lgrs_pkg::QPtrBits-1:0]      rd_ptr;
  logic [lgrs_pkg::QCntBits-1:0]      count;

  assign full       = (count == lgrs_pkg::QCntBits'(lgrs_pkg::QDepth));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lgrs_pkg::QPtrBits'(lgrs_pkg::QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lgrs_pkg::QPtrBits'(lgrs_pkg::QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + lgrs_pkg::QCntBits'(push) - lgrs_pkg::QCntBits'(pop);
    end
  end

endmodule
`default_nettype wire

### rtl/core/lgrs_front.sv
// Front end: takes rows, keeps the row window and queues work for the back end.
`default_nettype none
module lgrs_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lgrs_pkg::row_t        mask,
  lgrs_row_in_if.sink                cur_gen,
  input  wire logic                  q_full,
  output logic                       push,
  output lgrs_pkg::lgrs_entry_t      push_data
);

  lgrs_pkg::row_t row_above;
  lgrs_pkg::row_t row_middle;
  logic [1:0]     rows_seen;
  lgrs_pkg::row_t cur;
  logic           accept;
  logic           has_mid;

  assign cur_gen.ready = !q_full;
  assign accept        = cur_gen.valid && cur_gen.ready;
  assign cur           = cur_gen.row_cells & mask;
  assign has_mid       = (rows_seen != 2'd0);

  // first row of a multi-row grid only loads the window
  assign push = accept && (has_mid || cur_gen.last_row);
  assign push_data = '{above: row_above, middle: row_middle, cur: cur,
                       has_mid: has_mid, last: cur_gen.last_row};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_above  <= '0;
      row_middle <= '0;
      rows_seen  <= '0;
    end else if (accept) begin
      if (cur_gen.last_row) begin
        row_above  <= '0;
        row_middle <= '0;
        rows_seen  <= '0;
      end else begin
        row_above  <= has_mid ? row_middle : '0;
        row_middle <= cur;
        rows_seen  <= (rows_seen == 2'd2) ? rows_seen : rows_seen + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/lgrs_back.sv
// Back end: evaluates the stencil for queued entries into the output register.
`default_nettype none
module lgrs_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lgrs_pkg::row_t        mask,
  input  wire logic                  head_valid,
  input  wire lgrs_pkg::lgrs_entry_t head,
  output logic                       pop,
  lgrs_row_out_if.source             next_gen
);

  logic           phase;      // middle-row result of a two-result entry done
  logic           out_valid;
  lgrs_pkg::row_t out_row;
  logic           out_last;
  logic           emit_mid;
  logic           load;
  lgrs_pkg::row_t up, mid, down;

  assign emit_mid = head.has_mid && !phase;
  assign load     = head_valid && (!out_valid || next_gen.ready);
  assign pop      = load && !(emit_mid && head.last);

  always_comb begin
    if (emit_mid) begin
      up   = head.above;
      mid  = head.middle;
      down = head.cur;
    end else begin
      up   = head.has_mid ? head.middle : '0;
      mid  = head.cur;
      down = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        phase     <= emit_mid && head.last;
        out_valid <= 1'b1;
      end else if (next_gen.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row  <= lgrs_pkg::life_row(up, mid, down, mask);
      out_last <= !emit_mid;
    end
  end

  assign next_gen.valid    = out_valid;
  assign next_gen.next_row = out_row;
  assign next_gen.last_out = out_last;

endmodule
`default_nettype wire

### rtl/core/life_generation_row_stepper.sv
// Top level of the Life (B3/S23) row stepper.
`default_nettype none
// Streams a bounded grid one row per transaction on cur_gen, top to bottom, with
// last_row set on the final row, and returns the next generation on next_gen.
// The second row onwards each yields the successor of the row before it; the
// last row also yields its own successor, flagged by last_out, after which the
// block is ready for a fresh grid. A one-row grid gives one result. Cells left
// of column 0, outside the grid and at or above the effective width count as
// dead; result bits above the width are zero. The width register (cfg_wr_en,
// cfg_wr_data) resets to 64; 0 acts as 1 and values above ROW_CELLS saturate.
// Write it only while no results are owed; rows already held for the current
// grid are cut again to the new width.
// Rate: one row accepted per cycle while the queue has room. Each result takes
// its own turn in the back end's single stencil unit, so a last row that closes
// a multi-row grid holds the back end for both of its results. A row is written
// into the queue when it is accepted; the back end then loads its result from
// the queue head into the output register once that register is empty or its
// result is being taken. A two-entry queue separates the front from the
// back, and the output register lets the front keep taking rows while a result
// waits.
module life_generation_row_stepper #(
  parameter int ROW_CELLS = lgrs_pkg::RowCellsDflt
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  lgrs_row_in_if.sink                        cur_gen,
  lgrs_row_out_if.source                     next_gen,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lgrs_pkg::WidthBits-1:0] cfg_wr_data
);

  localparam logic [lgrs_pkg::WidthBits-1:0] CellsMax = lgrs_pkg::WidthBits'(ROW_CELLS);

  logic [lgrs_pkg::WidthBits-1:0] row_width;
  logic [lgrs_pkg::WidthBits-1:0] eff_width;
  lgrs_pkg::row_t                 mask;

  logic                  q_push;
  lgrs_pkg::lgrs_entry_t q_push_data;
  logic                  q_full;
  logic                  q_head_valid;
  lgrs_pkg::lgrs_entry_t q_head;
  logic                  q_pop;

  // width register; no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= lgrs_pkg::RowWidthReset;
    end else if (cfg_wr_en) begin
      row_width <= cfg_wr_data;
    end
  end

  // clamp to 1..ROW_CELLS, then expand to a cell mask
  always_comb begin
    if (row_width == '0) begin
      eff_width = lgrs_pkg::WidthBits'(1);
    end else if (row_width > CellsMax) begin
      eff_width = CellsMax;
    end else begin
      eff_width = row_width;
    end
    for (int i = 0; i < lgrs_pkg::RowBits; i++) begin
      mask[i] = (lgrs_pkg::WidthBits'(i) < eff_width);
    end
  end

  lgrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .mask      (mask),
    .cur_gen   (cur_gen),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  lgrs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  lgrs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mask       (mask),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .next_gen   (next_gen)
  );

endmodule
`default_nettype wire

### tb/life_generation_row_stepper_test.sv
// Self-checking bench for the Life row stepper: streamed grids against a local B3/S23 model.
module life_generation_row_stepper_test;
  import lgrs_pkg::*;

  localparam int CellsPerRow   = 64;
  // two register stages, plus the back end's second result for a closing last row
  localparam int DrainCycles   = 6;
  // cycles with no transaction on either channel before the run is abandoned
  localparam int WatchdogLimit = 4000;
  localparam int RandomRows    = 1650;

  typedef enum logic {ITEM_ROW, ITEM_WIDTH} item_kind_t;
  typedef enum logic [1:0] {RX_FLOW, RX_STALL, RX_JITTER} rx_mode_t;

  // one entry of the stimulus queue: a grid row, or a width write between rows
  typedef struct {
    item_kind_t           kind;
    row_t                 cells;
    logic                 last;
    logic                 drain;  // hold this row back until nothing is outstanding
    logic [WidthBits-1:0] width;
  } pend_item_t;

  typedef struct {
    row_t next_row;
    logic last_out;
  } gen_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [WidthBits-1:0] cfg_wr_data;

  lgrs_row_in_if  in_if ();
  lgrs_row_out_if out_if ();

  life_generation_row_stepper #(.ROW_CELLS(CellsPerRow)) u_top (
    .clk         (clk),
    .rst         (rst),
    .cur_gen     (in_if),
    .next_gen    (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Local model of the grid: width register, two held rows and a row count
  // that saturates at two. Rows and count follow every accepted input transaction.
  // ---------------------------------------------------------------------------
  logic [WidthBits-1:0] grid_width_reg;
  row_t                 grid_above;
  row_t                 grid_middle;
  int unsigned          grid_rows;

  gen_row_t   gen_rows_due[$];   // successor rows still owed by the block, oldest first
  pend_item_t pending_items[$];  // stimulus not yet handed to the driver
  int         errors;
  int         rows_total;
  int         rows_taken;

  // 0 behaves as 1, anything past the row size saturates
  function automatic int live_cols(logic [WidthBits-1:0] w);
    if (w == '0) return 1;
    if (int'(w) > CellsPerRow) return CellsPerRow;
    return int'(w);
  endfunction

  function automatic row_t cols_mask(int w);
    row_t m;
    m = '0;
    for (int i = 0; i < w; i++) m[i] = 1'b1;
    return m;
  endfunction

  // cells off either end of the live span are dead
  function automatic int alive_at(row_t r, int col, int w);
    if (col < 0 || col >= w) return 0;
    return int'(r[col]);
  endfunction

  // B3/S23 successor of mid, counting neighbours cell by cell
  function automatic row_t successor(row_t up, row_t mid, row_t down, int w);
    row_t res;
    int   n;
    res = '0;
    for (int i = 0; i < w; i++) begin
      n = 0;
      for (int d = -1; d <= 1; d++) begin
        n += alive_at(up, i + d, w) + alive_at(down, i + d, w);
        if (d != 0) n += alive_at(mid, i + d, w);
      end
      if (n == 3 || (mid[i] && n == 2)) res[i] = 1'b1;
    end
    return res;
  endfunction

  task automatic advance_grid(row_t cells, logic last);
    int       w;
    row_t     m;
    row_t     cur;
    gen_row_t g;
    w   = live_cols(grid_width_reg);
    m   = cols_mask(w);
    cur = cells & m;
    if (grid_rows != 0) begin
      // the held middle row is now closed from below
      g.next_row = successor(grid_above, grid_middle, cur, w);
      g.last_out = 1'b0;
      gen_rows_due.push_back(g);
      // rows held across a width change are cut again to the new width
      grid_above = grid_middle & m;
    end else begin
      grid_above = '0;
    end
    grid_middle = cur;
    if (grid_rows < 2) grid_rows++;
    if (last) begin
      // a dead row lies below the last one; the grid then starts afresh
      g.next_row = successor(grid_above, grid_middle, '0, w);
      g.last_out = 1'b1;
      gen_rows_due.push_back(g);
      grid_above  = '0;
      grid_middle = '0;
      grid_rows   = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels and the register port at the rising edge.
  // Predictions are made before checking, as results never share an edge
  // with the row that causes them.
  // ---------------------------------------------------------------------------
  logic     in_taken;
  logic     took_row;
  logic     took_res;
  int       idle_cycles;
  gen_row_t want;

  always @(posedge clk) begin
    took_row = in_if.valid && in_if.ready;
    took_res = out_if.valid && out_if.ready;
    if (rst) begin
      in_taken       <= 1'b0;
      grid_width_reg  = RowWidthReset;
      grid_above      = '0;
      grid_middle     = '0;
      grid_rows       = 0;
      idle_cycles     = 0;
    end else begin
      in_taken <= took_row;
      if (cfg_wr_en) grid_width_reg = cfg_wr_data;
      if (took_row) begin
        advance_grid(in_if.row_cells, in_if.last_row);
        rows_taken++;
      end
      if (took_res) begin
        if (gen_rows_due.size() == 0) begin
          $error("unexpected result: next_row %h last_out %b",
                 out_if.next_row, out_if.last_out);
          errors++;
        end else begin
          want = gen_rows_due.pop_front();
          if (out_if.next_row !== want.next_row) begin
            $error("next_row mismatch: expected %h, actual %h",
                   want.next_row, out_if.next_row);
            errors++;
          end
          if (out_if.last_out !== want.last_out) begin
            $error("last_out mismatch: expected %b, actual %b",
                   want.last_out, out_if.last_out);
            errors++;
          end
        end
      end
      // watchdog on transaction-free cycles
      if (took_row || took_res) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("life_generation_row_stepper_test: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver, both on the falling edge. The driver sends rows in
  // bursts with gaps between them; a width write waits until every owed
  // result is out and the pipeline has had time to settle.
  // ---------------------------------------------------------------------------
  pend_item_t           drv_head;
  logic                 drv_valid;
  row_t                 drv_cells;
  logic                 drv_last;
  logic                 drv_wr_en;
  logic [WidthBits-1:0] drv_wr_data;
  int                   burst_left;
  int                   gap_left;
  int                   settle;
  rx_mode_t             rx_mode;
  int                   rx_left;
  int                   rx_pick;
  logic                 rx_ready;

  always @(negedge clk) begin
    drv_valid   = in_if.valid;
    drv_cells   = in_if.row_cells;
    drv_last    = in_if.last_row;
    drv_wr_en   = 1'b0;
    drv_wr_data = cfg_wr_data;
    if (!rst) begin
      if (drv_valid && in_taken) drv_valid = 1'b0;
      if (!drv_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_items.size() != 0) begin
          drv_head = pending_items[0];
          if (drv_head.kind == ITEM_WIDTH) begin
            // only write once the block has gone quiet
            if (gen_rows_due.size() != 0) settle = 0;
            else if (settle < DrainCycles) settle++;
            else begin
              drv_wr_en   = 1'b1;
              drv_wr_data = drv_head.width;
              void'(pending_items.pop_front());
              settle = 0;
            end
          end else if (!drv_head.drain || gen_rows_due.size() == 0) begin
            void'(pending_items.pop_front());
            drv_valid = 1'b1;
            drv_cells = drv_head.cells;
            drv_last  = drv_head.last;
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 40);
              gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
              burst_left--;
            end
          end
        end
      end
    end
    in_if.valid     <= drv_valid;
    in_if.row_cells <= drv_cells;
    in_if.last_row  <= drv_last;
    cfg_wr_en       <= drv_wr_en;
    cfg_wr_data     <= drv_wr_data;

    // receiver: long free-flowing runs, stall runs and per-cycle jitter
    if (rx_left == 0) begin
      rx_pick = $urandom_range(0, 3);
      rx_mode = (rx_pick == 0) ? RX_STALL : (rx_pick == 1) ? RX_JITTER : RX_FLOW;
      rx_left = (rx_mode == RX_STALL) ? $urandom_range(1, 12) : $urandom_range(4, 48);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_STALL:  rx_ready = 1'b0;
      RX_JITTER: rx_ready = 1'($urandom_range(0, 1));
      default:   rx_ready = 1'b1;
    endcase
    out_if.ready <= rx_ready;
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_row(row_t cells, logic last, logic drain);
    pend_item_t it;
    it.kind  = ITEM_ROW;
    it.cells = cells;
    it.last  = last;
    it.drain = drain;
    it.width = '0;
    pending_items.push_back(it);
    rows_total++;
  endtask

  task automatic add_width(int w);
    pend_item_t it;
    it.kind  = ITEM_WIDTH;
    it.cells = '0;
    it.last  = 1'b0;
    it.drain = 1'b0;
    it.width = WidthBits'(w);
    pending_items.push_back(it);
  endtask

  // mixes empty, full, sparse, dense and uniform rows
  function automatic row_t random_row();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      3:       return {$urandom, $urandom} | {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int random_width();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 64;
      3:       return $urandom_range(65, 127);
      4:       return $urandom_range(2, 3);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  int grid_len;

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_if.valid     = 1'b0;
    in_if.row_cells = '0;
    in_if.last_row  = 1'b0;
    out_if.ready  = 1'b0;
    errors        = 0;
    rows_total    = 0;
    rows_taken    = 0;
    burst_left    = 0;
    gap_left      = 0;
    settle        = 0;
    rx_mode       = RX_FLOW;
    rx_left       = 0;

    // --- directed part, reset width of 64 first ---
    // one-row grids: single result each
    add_row('1, 1'b1, 1'b0);
    add_row('0, 1'b1, 1'b0);
    // solid block, both ends of the row live
    add_row('1, 1'b0, 1'b0);
    add_row('1, 1'b0, 1'b0);
    add_row('1, 1'b1, 1'b0);
    // blinker with corner cells; first row waits for an empty pipeline
    add_row(64'h8000_0000_0000_0001, 1'b0, 1'b1);
    add_row(64'h8000_0000_0000_0039, 1'b0, 1'b0);
    add_row(64'hC000_0000_0000_0003, 1'b1, 1'b0);
    // narrowest width
    add_width(1);
    add_row('1, 1'b0, 1'b0);
    add_row('1, 1'b1, 1'b0);
    // zero width acts as one column
    add_width(0);
    add_row('1, 1'b0, 1'b0);
    add_row(64'h1, 1'b0, 1'b0);
    add_row('1, 1'b1, 1'b0);
    // widths past the row size saturate
    add_width(127);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
    add_row(64'h5555_5555_5555_5555, 1'b1, 1'b0);
    add_width(65);
    add_row('1, 1'b1, 1'b0);
    // width narrowed while a grid is part-way through; held rows get cut again
    add_width(10);
    add_row(64'hFFFF, 1'b0, 1'b0);
    add_row(64'hFFFF, 1'b0, 1'b0);
    add_width(5);
    add_row(64'hFFFF, 1'b1, 1'b0);
    add_width(64);

    // --- random grids, mostly short, now and then a tall one ---
    while (rows_total < 22 + RandomRows) begin
      if ($urandom_range(0, 9) == 0) add_width(random_width());
      grid_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int r = 0; r < grid_len; r++)
        add_row(random_row(), r == grid_len - 1, $urandom_range(0, 199) == 0);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // every row in and every owed result out, then let the pipeline settle
    while (rows_taken != rows_total || gen_rows_due.size() != 0) @(negedge clk);
    repeat (DrainCycles + 2) @(negedge clk);

    if (errors == 0) begin
      $display("life_generation_row_stepper_test: done, clean");
    end else begin
      $display("life_generation_row_stepper_test: done, errors");
    end
    $finish;
  end

endmodule
